// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared sizes, codes and helpers of the binary max heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int IDX_W  = ADDR_W + 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DEL_CAP,
        S_DN_L,
        S_DN_R,
        S_DN_LR,
        S_DN_CMP,
        S_RESP
    } t_state;

    // zero acts as one, anything above the depth acts as the depth
    function automatic t_cnt eff_cap(input logic [CAP_W-1:0] cap);
        logic [31:0] c;
        c = 32'(cap);
        if (c == 32'd0) begin
            c = 32'd1;
        end
        if (c > 32'(DEPTH)) begin
            c = 32'(DEPTH);
        end
        return CNT_W'(c);
    endfunction

endpackage

// ===== rtl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bmhq_cmp.sv =====
// ----------------------------------------------------------------------------
// bmhq_cmp
// shared signed greater-than unit used by every sift step
// ----------------------------------------------------------------------------
module bmhq_cmp (
    input  bmhq_pkg::t_data i_a,
    input  bmhq_pkg::t_data i_b,
    output logic            o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

// ===== rtl/binary_max_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit
// binary max heap priority queue over a 64-entry ram
// ----------------------------------------------------------------------------
// input transaction: i_op (0 insert i_value, 1 delete maximum), taken when
// i_valid is high and o_stall is low. o_stall stays high from the accepted
// transaction until its result has been taken, so one operation is in work
// at a time.
// output transaction: o_removed_value, o_status, o_occupancy, taken when
// o_valid is high and i_stall is low; the result holds while i_stall is high
// and the next input is accepted in the cycle after it leaves.
// an insert climbs one level per read and compare of the parent until it reaches
// the root or meets a parent that is not smaller; a delete sinks the last entry
// from the root one level per read of the children and compare until it reaches a
// leaf or is not smaller than the larger child, and it skips the sinking when it
// empties the heap; one ram read port and one shared comparator set each step.
// ignored operations (insert when full, delete when empty) go straight to the response.
// i_cfg_we writes the capacity limit; write it only while idle.
// reset (synchronous, i_rst_n low) empties the heap and sets capacity to 64.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  bmhq_pkg::t_data              i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output bmhq_pkg::t_data              o_removed_value,
    output logic [1:0]                   o_status,
    output bmhq_pkg::t_cnt               o_occupancy,
    input  logic                         i_cfg_we,
    input  logic [bmhq_pkg::CAP_W-1:0]   i_cfg_data
);

    bmhq_pkg::t_state r_state, n_state;
    bmhq_pkg::t_data  r_cur, n_cur;
    bmhq_pkg::t_data  r_best, n_best;
    bmhq_pkg::t_addr  r_best_idx, n_best_idx;
    bmhq_pkg::t_addr  r_idx, n_idx;
    bmhq_pkg::t_cnt   r_cnt, n_cnt;
    bmhq_pkg::t_data  r_removed, n_removed;
    logic [1:0]       r_status, n_status;
    logic [bmhq_pkg::CAP_W-1:0] r_cap;

    logic             ram_we;
    bmhq_pkg::t_addr  ram_waddr;
    bmhq_pkg::t_data  ram_wdata;
    bmhq_pkg::t_addr  ram_raddr;
    bmhq_pkg::t_data  ram_rdata;

    bmhq_pkg::t_data  cmp_a;
    bmhq_pkg::t_data  cmp_b;
    logic             cmp_gt;

    logic [bmhq_pkg::ADDR_W:0]  lc_idx;
    logic [bmhq_pkg::IDX_W-1:0] lc_ext;
    logic [bmhq_pkg::IDX_W-1:0] rc_ext;
    logic [bmhq_pkg::IDX_W-1:0] cnt_ext;
    bmhq_pkg::t_addr            par_idx;

    assign lc_idx  = {r_idx, 1'b1};
    assign lc_ext  = bmhq_pkg::IDX_W'(lc_idx);
    assign rc_ext  = lc_ext + bmhq_pkg::IDX_W'(1);
    assign cnt_ext = bmhq_pkg::IDX_W'(r_cnt);
    assign par_idx = (r_idx - bmhq_pkg::ADDR_W'(1)) >> 1;

    bmhq_ram #(
        .WIDTH (bmhq_pkg::DATA_W),
        .DEPTH (bmhq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bmhq_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_cap   <= bmhq_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_idx      <= n_idx;
        r_removed  <= n_removed;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_removed  = r_removed;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = r_cur;
        ram_raddr  = par_idx;
        cmp_a      = r_best;
        cmp_b      = r_cur;

        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_removed = '0;
                    n_status  = bmhq_pkg::ST_DONE;
                    if (i_op == bmhq_pkg::OP_INSERT) begin
                        if (r_cnt >= bmhq_pkg::eff_cap(r_cap)) begin
                            n_status = bmhq_pkg::ST_FULL;
                            n_state  = bmhq_pkg::S_RESP;
                        end else begin
                            n_cur   = i_value;
                            n_idx   = bmhq_pkg::ADDR_W'(r_cnt);
                            n_cnt   = r_cnt + bmhq_pkg::CNT_W'(1);
                            n_state = bmhq_pkg::S_INS_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = bmhq_pkg::ST_EMPTY;
                            n_state  = bmhq_pkg::S_RESP;
                        end else begin
                            n_cnt   = r_cnt - bmhq_pkg::CNT_W'(1);
                            n_state = bmhq_pkg::S_DEL_ROOT;
                        end
                    end
                end
            end

            // hole at r_idx travels up, new value waits in r_cur
            bmhq_pkg::S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = bmhq_pkg::S_RESP;
                end else begin
                    ram_raddr = par_idx;
                    n_state   = bmhq_pkg::S_INS_CMP;
                end
            end

            bmhq_pkg::S_INS_CMP: begin
                cmp_a = r_cur;
                cmp_b = ram_rdata;
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_idx     = par_idx;
                    n_state   = bmhq_pkg::S_INS_RD;
                end else begin
                    n_state = bmhq_pkg::S_RESP;
                end
            end

            bmhq_pkg::S_DEL_ROOT: begin
                ram_raddr = '0;
                n_state   = bmhq_pkg::S_DEL_LAST;
            end

            bmhq_pkg::S_DEL_LAST: begin
                ram_raddr = bmhq_pkg::ADDR_W'(r_cnt);
                n_removed = ram_rdata;
                if (r_cnt == '0) begin
                    n_state = bmhq_pkg::S_RESP;
                end else begin
                    n_state = bmhq_pkg::S_DEL_CAP;
                end
            end

            // last entry becomes the value to sink from the root
            bmhq_pkg::S_DEL_CAP: begin
                n_cur   = ram_rdata;
                n_idx   = '0;
                n_state = bmhq_pkg::S_DN_L;
            end

            bmhq_pkg::S_DN_L: begin
                if (lc_ext >= cnt_ext) begin
                    ram_we  = 1'b1;
                    n_state = bmhq_pkg::S_RESP;
                end else begin
                    ram_raddr = bmhq_pkg::ADDR_W'(lc_idx);
                    n_state   = bmhq_pkg::S_DN_R;
                end
            end

            bmhq_pkg::S_DN_R: begin
                n_best     = ram_rdata;
                n_best_idx = bmhq_pkg::ADDR_W'(lc_idx);
                if (rc_ext < cnt_ext) begin
                    ram_raddr = bmhq_pkg::ADDR_W'(rc_ext);
                    n_state   = bmhq_pkg::S_DN_LR;
                end else begin
                    n_state = bmhq_pkg::S_DN_CMP;
                end
            end

            // right child wins only when strictly larger
            bmhq_pkg::S_DN_LR: begin
                cmp_a = ram_rdata;
                cmp_b = r_best;
                if (cmp_gt) begin
                    n_best     = ram_rdata;
                    n_best_idx = bmhq_pkg::ADDR_W'(rc_ext);
                end
                n_state = bmhq_pkg::S_DN_CMP;
            end

            bmhq_pkg::S_DN_CMP: begin
                cmp_a  = r_best;
                cmp_b  = r_cur;
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = r_best;
                    n_idx     = r_best_idx;
                    n_state   = bmhq_pkg::S_DN_L;
                end else begin
                    n_state = bmhq_pkg::S_RESP;
                end
            end

            bmhq_pkg::S_RESP: begin
                if (!i_stall) begin
                    n_state = bmhq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall         = (r_state != bmhq_pkg::S_IDLE);
    assign o_valid         = (r_state == bmhq_pkg::S_RESP);
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_occupancy     = r_cnt;

endmodule
